// File: hdl/ctfq_pkg.sv
// Package: shared types and constants for the CAN transmit frame queue.
`timescale 1ns / 1ps

package ctfq_pkg;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    // One stored CAN frame.
    typedef struct packed {
        logic [7:0]  port;
        logic [7:0]  board;
        logic [31:0] tick;
        logic [10:0] std_id;
        logic [28:0] ext_id;
        logic        ide;
        logic        rtr;
        logic [3:0]  dlc;
        logic [63:0] payload;
    } t_frame;

    localparam int FRAME_W = $bits(t_frame);

    // Status of one processed item.
    typedef struct packed {
        logic accepted;
        logic pop_valid;
        logic full_flag;
    } t_flags;

    // One result item.
    typedef struct packed {
        t_flags flags;
        t_frame frame;
    } t_result;

    // Output queue size, enough to cover the two-stage read pipeline.
    localparam int OUT_DEPTH = 4;
    localparam int OUT_AW    = $clog2(OUT_DEPTH);
    localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

endpackage

// File: hdl/can_tx_frame_queue.sv
// Top level of the CAN transmit frame queue.
`timescale 1ns / 1ps

// Transmit queue for CAN frames, DEPTH slots deep. Each input item carries a
// command: push a frame, pop the oldest frame, or clear the sticky full flag
// (the fourth code does nothing). Every item yields exactly one result item
// with the accepted and pop_valid flags, the popped frame (all zero unless
// pop_valid) and the full flag as it stands after the command. A push is
// taken only while the full flag is clear; once DEPTH frames are queued the
// flag sets, and a push after a clear command overwrites the next ring slot
// without queueing it. The flag clears when a pop empties the queue or on a
// clear command. Throughput is one item per clock while o_stall is low.
// Each result comes from a read of the slot-index RAM followed by a read of
// the frame RAM at that slot. Results then wait in a four-entry output
// queue; o_stall rises when that queue plus the two pipeline stages could
// be full, so a downstream stall backs up to the input. Frame slots hold
// nothing meaningful until written; only slots that were pushed are ever
// read back.
module can_tx_frame_queue #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_port_in,
    input  logic [7:0]  i_board_in,
    input  logic [31:0] i_tick_in,
    input  logic [10:0] i_std_id_in,
    input  logic [28:0] i_ext_id_in,
    input  logic        i_ide_in,
    input  logic        i_rtr_in,
    input  logic [3:0]  i_dlc_in,
    input  logic [63:0] i_payload_in,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_accepted,
    output logic        o_pop_valid,
    output logic [7:0]  o_port_out,
    output logic [7:0]  o_board_out,
    output logic [31:0] o_tick_out,
    output logic [10:0] o_std_id_out,
    output logic [28:0] o_ext_id_out,
    output logic        o_ide_out,
    output logic        o_rtr_out,
    output logic [3:0]  o_dlc_out,
    output logic [63:0] o_payload_out,
    output logic        o_full_flag
);
    import ctfq_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic          accept;
    t_cmd          cmd;
    t_frame        frame_in;
    t_frame        frame_rd;
    logic          frame_we, idx_we;
    logic [AW-1:0] slot, idx_waddr, idx_raddr, idx_rdata;
    t_flags        flags;

    // Pipeline stage flags: s1 = index read in flight, s2 = frame read done.
    logic          r_s1_valid, r_s2_valid;
    t_flags        r_s1_flags, r_s2_flags;

    t_result       result_in, result_out;
    logic [OUT_CW-1:0] q_count;
    logic [OUT_CW-1:0] occupancy;

    // Credit check: every item in flight has a guaranteed queue entry.
    assign occupancy = q_count + OUT_CW'(r_s1_valid) + OUT_CW'(r_s2_valid);
    assign o_stall   = (occupancy >= OUT_CW'(OUT_DEPTH));
    assign accept    = i_valid && !o_stall;
    assign cmd       = t_cmd'(i_command);

    assign frame_in.port    = i_port_in;
    assign frame_in.board   = i_board_in;
    assign frame_in.tick    = i_tick_in;
    assign frame_in.std_id  = i_std_id_in;
    assign frame_in.ext_id  = i_ext_id_in;
    assign frame_in.ide     = i_ide_in;
    assign frame_in.rtr     = i_rtr_in;
    assign frame_in.dlc     = i_dlc_in;
    assign frame_in.payload = i_payload_in;

    ctfq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_cmd       (cmd),
        .o_frame_we  (frame_we),
        .o_slot      (slot),
        .o_idx_we    (idx_we),
        .o_idx_waddr (idx_waddr),
        .o_idx_raddr (idx_raddr),
        .o_flags     (flags)
    );

    // Slot numbers of queued frames, oldest at the read pointer.
    ctfq_ram #(
        .WIDTH (AW),
        .DEPTH (DEPTH)
    ) u_idx_ram (
        .i_clk   (i_clk),
        .i_we    (idx_we),
        .i_waddr (idx_waddr),
        .i_wdata (slot),
        .i_raddr (idx_raddr),
        .o_rdata (idx_rdata)
    );

    // Frame ring. The read in the clock after a pop sees the slot before any
    // push taken in that same clock (read-first), which is the right order.
    ctfq_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (DEPTH)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (frame_we),
        .i_waddr (slot),
        .i_wdata (frame_in),
        .i_raddr (idx_rdata),
        .o_rdata (frame_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_flags <= flags;
        r_s2_flags <= r_s1_flags;
    end

    // Frame fields read as zero on every result that is not a pop.
    assign result_in.flags = r_s2_flags;
    assign result_in.frame = r_s2_flags.pop_valid ? frame_rd : '0;

    ctfq_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s2_valid),
        .i_data  (result_in),
        .i_pop   (!i_stall),
        .o_valid (o_valid),
        .o_data  (result_out),
        .o_count (q_count)
    );

    assign o_accepted    = result_out.flags.accepted;
    assign o_pop_valid   = result_out.flags.pop_valid;
    assign o_full_flag   = result_out.flags.full_flag;
    assign o_port_out    = result_out.frame.port;
    assign o_board_out   = result_out.frame.board;
    assign o_tick_out    = result_out.frame.tick;
    assign o_std_id_out  = result_out.frame.std_id;
    assign o_ext_id_out  = result_out.frame.ext_id;
    assign o_ide_out     = result_out.frame.ide;
    assign o_rtr_out     = result_out.frame.rtr;
    assign o_dlc_out     = result_out.frame.dlc;
    assign o_payload_out = result_out.frame.payload;

endmodule

// File: hdl/ctfq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module ctfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read-first: a read and write to the same address return the old word.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/ctfq_ctrl.sv
// Queue control: slot pointer, index FIFO pointers, entry count and sticky full flag.
`timescale 1ns / 1ps

module ctfq_ctrl #(
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  ctfq_pkg::t_cmd           i_cmd,
    output logic                     o_frame_we,
    output logic [$clog2(DEPTH)-1:0] o_slot,
    output logic                     o_idx_we,
    output logic [$clog2(DEPTH)-1:0] o_idx_waddr,
    output logic [$clog2(DEPTH)-1:0] o_idx_raddr,
    output ctfq_pkg::t_flags         o_flags
);
    import ctfq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    logic [AW-1:0] r_slot, n_slot;
    logic [AW-1:0] r_in,   n_in;
    logic [AW-1:0] r_out,  n_out;
    logic [CW-1:0] r_count, n_count;
    logic          r_full,  n_full;
    logic          frame_we, idx_we, accepted, pop_valid;

    always_comb begin
        n_slot    = r_slot;
        n_in      = r_in;
        n_out     = r_out;
        n_count   = r_count;
        n_full    = r_full;
        frame_we  = 1'b0;
        idx_we    = 1'b0;
        accepted  = 1'b0;
        pop_valid = 1'b0;
        if (i_accept) begin
            case (i_cmd)
                CMD_PUSH: begin
                    if (!r_full) begin
                        accepted = 1'b1;
                        frame_we = 1'b1;
                        n_slot   = (r_slot == LAST) ? '0 : r_slot + 1'b1;
                        if (r_count == FULL) begin
                            // index FIFO already holds every slot: overwrite only
                            n_full = 1'b1;
                        end else begin
                            idx_we  = 1'b1;
                            n_in    = (r_in == LAST) ? '0 : r_in + 1'b1;
                            n_count = r_count + 1'b1;
                            if (n_count == FULL) begin
                                n_full = 1'b1;
                            end
                        end
                    end
                end
                CMD_POP: begin
                    if (r_count != '0) begin
                        pop_valid = 1'b1;
                        n_out     = (r_out == LAST) ? '0 : r_out + 1'b1;
                        n_count   = r_count - 1'b1;
                        if (n_count == '0) begin
                            n_full = 1'b0;
                        end
                    end
                end
                CMD_CLEAR: begin
                    n_full = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_in    <= '0;
            r_out   <= '0;
            r_count <= '0;
            r_full  <= 1'b0;
        end else begin
            r_slot  <= n_slot;
            r_in    <= n_in;
            r_out   <= n_out;
            r_count <= n_count;
            r_full  <= n_full;
        end
    end

    assign o_frame_we          = frame_we;
    assign o_slot              = r_slot;
    assign o_idx_we            = idx_we;
    assign o_idx_waddr         = r_in;
    assign o_idx_raddr         = r_out;
    assign o_flags.accepted    = accepted;
    assign o_flags.pop_valid   = pop_valid;
    assign o_flags.full_flag   = n_full;

endmodule

// File: hdl/ctfq_out_fifo.sv
// Small result queue that decouples the read pipeline from output stalls.
`timescale 1ns / 1ps

module ctfq_out_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  ctfq_pkg::t_result             i_data,
    input  logic                          i_pop,
    output logic                          o_valid,
    output ctfq_pkg::t_result             o_data,
    output logic [ctfq_pkg::OUT_CW-1:0]   o_count
);
    import ctfq_pkg::*;

    t_result           r_buf [OUT_DEPTH];
    logic [OUT_AW-1:0] r_wr, r_rd;
    logic [OUT_CW-1:0] r_count;
    logic              pop;

    assign pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + OUT_CW'(i_push) - OUT_CW'(pop);
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_buf[r_rd];
    assign o_count = r_count;

endmodule
